// ===== src/odtb_pkg.sv =====
package odtb_pkg;

  localparam int MATRIX_SIZE    = 16;
  localparam int MAX_ROW_GROUPS = 256;
  localparam int ALL_PLANES     = 8;
  localparam int QUEUE_DEPTH    = 4;

  localparam int PIX_W   = $clog2(MATRIX_SIZE);
  localparam int ADDR_W  = 2 * PIX_W;
  localparam int GRP_W   = 8;
  localparam int PLANE_W = 3;
  localparam int CNT_W   = 4;
  localparam int WORD_W  = 16;
  localparam int QA_W    = $clog2(QUEUE_DEPTH);

  localparam logic [WORD_W-1:0] FIRST_PIX_MASK = 16'h8000;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SOF   = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_PLANES = 2'd1;
  localparam logic [1:0] CFG_BASE   = 2'd2;

  localparam logic       MODE_RST   = 1'b0;
  localparam logic [3:0] PLANES_RST = 4'd4;
  localparam logic [7:0] BASE_RST   = 8'd32;

  typedef struct packed {
    logic       mode;
    logic [3:0] plane_count;
    logic [7:0] base;
  } cfg_t;

  typedef struct packed {
    logic [ALL_PLANES-1:0][WORD_W-1:0] words;
    logic [CNT_W-1:0]                  n;
    logic [GRP_W-1:0]                  column;
  } group_t;

  // Six-level quantization of one channel against a threshold.
  function automatic logic [2:0] chan_level(logic [7:0] c, logic [7:0] th);
    logic [10:0] v;
    v = 11'(c) * 11'd5;
    return v[10:8] + 3'(th < v[7:0]);
  endfunction

  function automatic logic [CNT_W-1:0] active_planes(cfg_t cfg);
    logic [CNT_W-1:0] n;
    if (cfg.mode) begin
      n = CNT_W'(ALL_PLANES);
    end else if (cfg.plane_count == 4'd0) begin
      n = CNT_W'(1);
    end else if (cfg.plane_count > CNT_W'(ALL_PLANES)) begin
      n = CNT_W'(ALL_PLANES);
    end else begin
      n = cfg.plane_count;
    end
    return n;
  endfunction

endpackage

// ===== src/odtb_front.sv =====
module odtb_front import odtb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_opcode,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  logic             in_row_end,
  input  logic [7:0]       in_matrix_slot,
  input  logic [7:0]       in_matrix_value,
  input  cfg_t             cfg,
  input  logic             q_full,
  output logic             push,
  output group_t           push_data
);

  logic [7:0]       mat_mem [MATRIX_SIZE*MATRIX_SIZE];

  logic [PIX_W-1:0] pix_r;
  logic [GRP_W-1:0] grp_r;
  logic [PIX_W-1:0] phase_r;

  logic             s2_valid_r;
  op_t              s2_op_r;
  logic [7:0]       s2_red_r, s2_green_r, s2_blue_r;
  logic [PIX_W-1:0] s2_pix_r;
  logic [GRP_W-1:0] s2_col_r;
  logic             s2_emit_r;
  logic [7:0]       th_r;

  logic [ALL_PLANES-1:0][WORD_W-1:0] acc_r;
  logic [ALL_PLANES-1:0][WORD_W-1:0] acc_or;

  op_t              in_op;
  logic             accept;
  logic             s2_adv;
  logic             emit_now;
  logic [ADDR_W-1:0] mat_addr;
  logic             gt_r, gt_g, gt_b;
  logic [2:0]       lvl_r, lvl_g, lvl_b;
  logic [7:0]       pal_idx;
  logic [7:0]       bits;
  logic [CNT_W-1:0] n_planes;
  logic [WORD_W-1:0] pix_mask;

  assign in_op    = op_t'(in_opcode);
  assign s2_adv   = !(s2_valid_r && (s2_op_r == OP_PIXEL) && s2_emit_r && q_full);
  assign in_ready = s2_adv;
  assign accept   = in_valid && in_ready;
  assign emit_now = (pix_r == PIX_W'(MATRIX_SIZE - 1)) || in_row_end;
  assign mat_addr = {phase_r, pix_r};

  // Position tracking happens at accept so the matrix read sees the right slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r   <= '0;
      grp_r   <= '0;
      phase_r <= '0;
    end else if (accept) begin
      unique case (in_op)
        OP_PIXEL: begin
          if (emit_now) begin
            pix_r <= '0;
            if (in_row_end) begin
              grp_r   <= '0;
              phase_r <= phase_r + PIX_W'(1);
            end else if (grp_r == GRP_W'(MAX_ROW_GROUPS - 1)) begin
              grp_r <= '0;
            end else begin
              grp_r <= grp_r + GRP_W'(1);
            end
          end else begin
            pix_r <= pix_r + PIX_W'(1);
          end
        end
        OP_SOF: begin
          pix_r   <= '0;
          grp_r   <= '0;
          phase_r <= '0;
        end
        OP_LOAD, OP_NOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_LOAD)) begin
      mat_mem[in_matrix_slot] <= in_matrix_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      th_r <= mat_mem[mat_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_op_r    <= in_op;
      s2_red_r   <= in_red;
      s2_green_r <= in_green;
      s2_blue_r  <= in_blue;
      s2_pix_r   <= pix_r;
      s2_col_r   <= grp_r;
      s2_emit_r  <= emit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_ready) begin
      s2_valid_r <= in_valid;
    end
  end

  // Classification of the pixel into plane bits.
  always_comb begin
    gt_r     = th_r < s2_red_r;
    gt_g     = th_r < s2_green_r;
    gt_b     = th_r < s2_blue_r;
    lvl_r    = chan_level(s2_red_r, th_r);
    lvl_g    = chan_level(s2_green_r, th_r);
    lvl_b    = chan_level(s2_blue_r, th_r);
    pal_idx  = (8'(lvl_r) * 8'd6 + 8'(lvl_g)) * 8'd6 + 8'(lvl_b);
    n_planes = active_planes(cfg);
    pix_mask = FIRST_PIX_MASK >> s2_pix_r;
    if (cfg.mode) begin
      bits = pal_idx + cfg.base;
    end else if (!gt_r && !gt_g && !gt_b) begin
      bits = 8'hFF;
    end else if (gt_r && gt_g && gt_b) begin
      bits = 8'h00;
    end else begin
      bits = {5'b0, gt_b, gt_g, gt_r};
    end
    for (int k = 0; k < ALL_PLANES; k++) begin
      if (bits[k] && (CNT_W'(k) < n_planes)) begin
        acc_or[k] = acc_r[k] | pix_mask;
      end else begin
        acc_or[k] = acc_r[k];
      end
    end
  end

  assign push             = s2_valid_r && (s2_op_r == OP_PIXEL) && s2_emit_r && !q_full;
  assign push_data.words  = acc_or;
  assign push_data.n      = n_planes;
  assign push_data.column = s2_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (s2_valid_r && s2_adv) begin
      unique case (s2_op_r)
        OP_PIXEL: acc_r <= s2_emit_r ? '0 : acc_or;
        OP_SOF:   acc_r <= '0;
        OP_LOAD, OP_NOP: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_adv |=> s2_valid_r && $stable(s2_col_r) && $stable(s2_pix_r))
    else $error("stage two lost its pixel while the queue was full");
`endif

endmodule

// ===== src/odtb_queue.sv =====
module odtb_queue import odtb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  group_t push_data,
  output logic   full,
  output logic   q_valid,
  output group_t head,
  input  logic   pop
);

  group_t          entry_r [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QA_W:0]   count_r;

  assign full    = (count_r == (QA_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QA_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QA_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QA_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QA_W+1)'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QA_W+1)'(QUEUE_DEPTH))
    else $error("group queue count beyond its depth");
  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + (QA_W+1)'(1))
    else $error("group queue count did not follow a push");
`endif

endmodule

// ===== src/odtb_back.sv =====
module odtb_back import odtb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  group_t             head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  out_plane_word,
  output logic [PLANE_W-1:0] out_plane_number,
  output logic [GRP_W-1:0]   out_word_column,
  output logic               out_last_plane
);

  logic [PLANE_W-1:0] plane_r;
  logic               out_valid_r;
  logic [WORD_W-1:0]  word_r;
  logic [PLANE_W-1:0] num_r;
  logic [GRP_W-1:0]   col_r;
  logic               last_r;
  logic               load;
  logic               is_last;

  assign is_last = (CNT_W'(plane_r) + CNT_W'(1)) == head.n;
  assign load    = q_valid && (!out_valid_r || out_ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        plane_r     <= is_last ? '0 : plane_r + PLANE_W'(1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= head.words[plane_r];
      num_r  <= plane_r;
      col_r  <= head.column;
      last_r <= is_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_plane_word   = word_r;
  assign out_plane_number = num_r;
  assign out_word_column  = col_r;
  assign out_last_plane   = last_r;

`ifndef SYNTH
  a_plane_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> CNT_W'(plane_r) < head.n)
    else $error("plane counter ran past the group's plane count");
`endif

endmodule

// ===== src/ordered_dither_to_bitplanes_core.sv =====
// Ordered dither of an RGB pixel stream into 16-pixel bitplane words.
// Input channel (in_valid/in_ready): one request per cycle carries a pixel,
// a dither matrix load or a start of frame, selected by in_opcode. Pixels are
// compared with the loaded 16x16 threshold matrix and their plane bits are
// gathered MSB first; a full group of 16 pixels or a row end emits a group.
// Output channel (out_valid/out_ready): one plane word per request, planes in
// ascending order, out_last_plane on the final word of a group. A group gives
// the programmed plane count of words in three-bit mode (zero read as one,
// above eight as eight) and 8 in palette mode. Configuration channel
// (cfg_valid/cfg_ready): always ready; write the registers only while no
// pixel is in flight. Throughput: one input request per cycle while
// in_ready is high, limited by the single matrix read port and one-stage
// classification; the output side drains one word per cycle from a
// four-group queue while out_ready is high.
// When the receiver stalls, groups collect in the queue; once it is full and a
// further group closes, in_ready drops until a slot frees.
// Reset (rst_n, synchronous, active low) clears positions, plane accumulators,
// the queue and the output valid flag, and restores the register defaults. The
// matrix is not cleared: load every entry before sending pixels.
module ordered_dither_to_bitplanes_core import odtb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_opcode,
  input  logic [7:0]   in_red,
  input  logic [7:0]   in_green,
  input  logic [7:0]   in_blue,
  input  logic         in_row_end,
  input  logic [7:0]   in_matrix_slot,
  input  logic [7:0]   in_matrix_value,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [15:0]  out_plane_word,
  output logic [2:0]   out_plane_number,
  output logic [7:0]   out_word_column,
  output logic         out_last_plane,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  cfg_t   cfg_r;
  logic   q_full;
  logic   push;
  group_t push_data;
  logic   q_valid;
  group_t head;
  logic   pop;

  // The configuration port never stalls; an index past the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_RST;
      cfg_r.plane_count <= PLANES_RST;
      cfg_r.base        <= BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MODE) begin
        cfg_r.mode <= cfg_data[0];
      end else if (cfg_index == CFG_PLANES) begin
        cfg_r.plane_count <= cfg_data[3:0];
      end else if (cfg_index == CFG_BASE) begin
        cfg_r.base <= cfg_data;
      end
    end
  end

  // Front end: position tracking, matrix, classification and accumulation.
  odtb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_row_end      (in_row_end),
    .in_matrix_slot  (in_matrix_slot),
    .in_matrix_value (in_matrix_value),
    .cfg             (cfg_r),
    .q_full          (q_full),
    .push            (push),
    .push_data       (push_data)
  );

  // Completed groups wait here so each side can stall on its own.
  odtb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop)
  );

  // Back end: serializes a group into plane words behind an output register.
  odtb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_plane_word   (out_plane_word),
    .out_plane_number (out_plane_number),
    .out_word_column  (out_word_column),
    .out_last_plane   (out_last_plane)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import odtb_pkg::*;

  localparam int MAX_GAP       = 13;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 112;
  localparam int RANDOM_PHASES = 8;
  localparam int PRINT_LIMIT   = 100;

  typedef struct packed {
    logic [15:0] word;
    logic [2:0]  plane;
    logic [7:0]  column;
    logic        last;
  } plane_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        in_row_end;
  logic [7:0]  in_matrix_slot;
  logic [7:0]  in_matrix_value;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_plane_word;
  logic [2:0]  out_plane_number;
  logic [7:0]  out_word_column;
  logic        out_last_plane;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Shadow copy of the block: threshold matrix, per-plane accumulators,
  // position counters and the three configuration registers.
  logic [7:0]  thresholds [256];
  logic [15:0] plane_bits [ALL_PLANES];
  int          pix_pos;
  int          group_pos;
  int          row_pos;
  logic        mode_reg;
  logic [3:0]  planes_reg;
  logic [7:0]  base_reg;

  // Plane words predicted but not yet seen on the output channel, oldest first.
  plane_word_t pending_words[$];
  int          mismatches = 0;

  // Idle shaping: the steady flags turn off the random gaps for a stretch on
  // one side.
  bit in_steady  = 1'b0;
  bit out_steady = 1'b0;

  ordered_dither_to_bitplanes_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_row_end       (in_row_end),
    .in_matrix_slot   (in_matrix_slot),
    .in_matrix_value  (in_matrix_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_plane_word   (out_plane_word),
    .out_plane_number (out_plane_number),
    .out_word_column  (out_word_column),
    .out_last_plane   (out_last_plane),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Number of plane words a group produces under the current settings. In
  // three-bit mode a plane count of zero behaves as one and anything above
  // eight behaves as eight.
  function automatic int planes_out();
    if (mode_reg) return ALL_PLANES;
    if (planes_reg == 4'd0) return 1;
    if (planes_reg > 4'd8) return ALL_PLANES;
    return int'(planes_reg);
  endfunction

  // One of six levels per channel: the whole part of channel*5/256 plus one
  // more when the fraction clears the threshold.
  function automatic int six_level(input logic [7:0] c, input logic [7:0] th);
    logic [10:0] v;
    v = 11'(c) * 11'd5;
    return int'(v[10:8]) + ((th < v[7:0]) ? 1 : 0);
  endfunction

  task automatic reset_model();
    foreach (thresholds[i]) thresholds[i] = '0;
    foreach (plane_bits[k]) plane_bits[k] = '0;
    pix_pos    = 0;
    group_pos  = 0;
    row_pos    = 0;
    mode_reg   = MODE_RST;
    planes_reg = PLANES_RST;
    base_reg   = BASE_RST;
  endtask

  // Applies one accepted request to the shadow state and queues the plane
  // words that it closes, if any.
  task automatic predict_request(input op_t op, input logic [7:0] r, g, b,
                                 input logic re, input logic [7:0] slot, value);
    logic [7:0] th;
    logic [7:0] bits;
    logic [2:0] code;
    int         n;
    int         idx;
    case (op)
      OP_LOAD: begin
        thresholds[slot] = value;
      end
      OP_SOF: begin
        // A partial group is thrown away without output.
        foreach (plane_bits[k]) plane_bits[k] = '0;
        pix_pos   = 0;
        group_pos = 0;
        row_pos   = 0;
      end
      OP_PIXEL: begin
        th   = thresholds[{row_pos[3:0], pix_pos[3:0]}];
        n    = planes_out();
        bits = '0;
        if (!mode_reg) begin
          code = {th < r, th < g, th < b};
          // Black lights every plane, white none, any other code maps red,
          // green and blue onto planes 0, 1 and 2.
          if (code == 3'b000) begin
            bits = 8'hFF;
          end else if (code != 3'b111) begin
            bits = {5'b0, code[0], code[1], code[2]};
          end
        end else begin
          idx  = (six_level(r, th) * 6 + six_level(g, th)) * 6 + six_level(b, th);
          bits = 8'(idx + int'(base_reg));
        end
        for (int k = 0; k < n; k++) begin
          if (bits[k]) plane_bits[k][15 - pix_pos] = 1'b1;
        end
        pix_pos++;
        // A group that fills on a row-end pixel goes out once only.
        if (pix_pos == 16 || re) begin
          for (int k = 0; k < n; k++) begin
            pending_words.push_back('{plane_bits[k], 3'(k), 8'(group_pos), k == n - 1});
          end
          foreach (plane_bits[k]) plane_bits[k] = '0;
          pix_pos = 0;
          if (re) begin
            group_pos = 0;
            row_pos   = (row_pos + 1) % 16;
          end else begin
            group_pos = (group_pos + 1) % MAX_ROW_GROUPS;
          end
        end
      end
      default: begin
        // The spare opcode leaves everything as it was.
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  function automatic int draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Presents one request at a falling edge and holds it until the block takes
  // it. Valid stays high on return, so a following request with no gap goes
  // out back to back; settle() lowers it when the stream pauses.
  task automatic send_request(input op_t op, input logic [7:0] r, g, b,
                              input logic re, input logic [7:0] slot, value);
    int gap;
    gap = draw_gap(in_steady);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode       = op;
    in_red          = r;
    in_green        = g;
    in_blue         = b;
    in_row_end      = re;
    in_matrix_slot  = slot;
    in_matrix_value = value;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_request(op, r, g, b, re, slot, value);
  endtask

  // Pixel requests carry random junk in the matrix fields, and the other
  // kinds carry random junk in the pixel fields.
  task automatic send_pixel(input logic [7:0] r, g, b, input logic re);
    send_request(OP_PIXEL, r, g, b, re, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_load(input logic [7:0] slot, value);
    send_request(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                 slot, value);
  endtask

  task automatic send_marker(input op_t op);
    send_request(op, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                 8'($urandom), 8'($urandom));
  endtask

  // Ends the request stream, waits for every predicted word, then keeps
  // waiting in case a request without output is still inside.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_MODE:   mode_reg   = data[0];
      CFG_PLANES: planes_reg = data[3:0];
      CFG_BASE:   base_reg   = data;
      default:    ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Writes all three registers once the block is idle. The unused upper data
  // bits carry random values, which the block must ignore.
  task automatic configure(input logic mode, input logic [3:0] planes,
                           input logic [7:0] base);
    settle();
    write_register(CFG_MODE, {7'($urandom), mode});
    write_register(CFG_PLANES, {4'($urandom), planes});
    write_register(CFG_BASE, base);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every matrix entry is written before the first pixel, so no pixel ever
  // reads an entry that holds no value yet. The corner entries get the two
  // threshold extremes.
  task automatic test_load_matrix();
    for (int slot = 0; slot < 256; slot++) begin
      if (slot == 0) begin
        send_load(8'(slot), 8'h00);
      end else if (slot == 255) begin
        send_load(8'(slot), 8'hFF);
      end else begin
        send_load(8'(slot), 8'($urandom));
      end
    end
  endtask

  // Runs under the reset settings: four planes in three-bit mode. Black,
  // white and the six primary and secondary colors, then random pixels, and
  // the group fills on the pixel that also ends the row.
  task automatic test_color_codes();
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    for (int i = 8; i < 16; i++) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 15);
    end
  endtask

  // The spare opcode and a matrix load land in the middle of a group; the
  // reloaded entry is the one the following pixel reads. The row then ends
  // on a partial group.
  task automatic test_ignored_and_load();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    send_marker(OP_NOP);
    send_load({4'd1, 4'd1}, 8'h80);
    send_pixel(8'h80, 8'h81, 8'h7F, 1'b1);
  endtask

  // Start of frame drops a partial group and restarts at row phase zero.
  task automatic test_start_of_frame();
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    send_marker(OP_SOF);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
  endtask

  // Plane counts at both ends of the legal range and beyond it on both sides.
  task automatic test_plane_count_limits();
    logic [3:0] counts [4];
    counts = '{4'd0, 4'd15, 4'd1, 4'd8};
    foreach (counts[i]) begin
      configure(1'b0, counts[i], BASE_RST);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    end
  endtask

  // Palette mode with the smallest and largest base; the largest makes the
  // index wrap past 255.
  task automatic test_palette_base();
    logic [7:0] bases [2];
    bases = '{8'h00, 8'hFF};
    foreach (bases[i]) begin
      configure(1'b1, 4'd4, bases[i]);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    end
  endtask

  // The mode is switched while a group is half built. The mode in force when
  // the group closes decides how many plane words leave.
  task automatic test_mode_switch_in_group();
    configure(1'b0, 4'd2, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    configure(1'b1, 4'd2, 8'h55);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    configure(1'b0, 4'd3, 8'h55);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
  endtask

  // Mostly pixels with random content and rows of random length, mixed with
  // matrix reloads, frame starts and the spare opcode. Each phase runs under
  // its own settings; the first six visit the extremes.
  task automatic test_random_traffic();
    int         sent;
    int         pick;
    int         style;
    logic [7:0] r, g, b;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       configure(1'b0, 4'd1, 8'h00);
        1:       configure(1'b0, 4'd8, 8'hFF);
        2:       configure(1'b1, 4'($urandom), 8'h00);
        3:       configure(1'b1, 4'($urandom), 8'hFF);
        4:       configure(1'b0, 4'd0, 8'($urandom));
        5:       configure(1'b0, 4'd15, 8'($urandom));
        default: configure(1'($urandom), 4'($urandom), 8'($urandom));
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
        pick = $urandom_range(0, 99);
        if (pick < 84) begin
          // Solid black and white and saturated colors show up more often
          // than chance alone would give them.
          style = $urandom_range(0, 7);
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
          if (style == 0) begin
            r = 8'h00; g = 8'h00; b = 8'h00;
          end else if (style == 1) begin
            r = 8'hFF; g = 8'hFF; b = 8'hFF;
          end else if (style == 2) begin
            r = {8{r[0]}}; g = {8{g[0]}}; b = {8{b[0]}};
          end
          send_pixel(r, g, b, $urandom_range(0, 15) == 0);
          sent++;
        end else if (pick < 91) begin
          send_load(8'($urandom), 8'($urandom));
          sent++;
        end else if (pick < 95) begin
          send_marker(OP_SOF);
          sent++;
        end else begin
          send_marker(OP_NOP);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------------

  function automatic void flag_mismatch(input string field, input logic [15:0] want, got);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  // The receiver draws a stall before every plane word, then holds ready high
  // until the word is taken. Each word is compared with the oldest prediction.
  initial begin : plane_word_checker
    plane_word_t want;
    int          stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = draw_gap(out_steady);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
          $display("%0t ns: unexpected plane word 0x%0h on plane %0d, expected none",
                   $time, out_plane_word, out_plane_number);
        end
      end else begin
        want = pending_words.pop_front();
        if (out_plane_word !== want.word) begin
          flag_mismatch("plane_word", want.word, out_plane_word);
        end
        if (out_plane_number !== want.plane) begin
          flag_mismatch("plane_number", 16'(want.plane), 16'(out_plane_number));
        end
        if (out_word_column !== want.column) begin
          flag_mismatch("word_column", 16'(want.column), 16'(out_word_column));
        end
        if (out_last_plane !== want.last) begin
          flag_mismatch("last_plane", 16'(want.last), 16'(out_last_plane));
        end
      end
    end
  end

  // Every so often each side either goes steady for a while or returns to
  // random idling, so both long bursts and scattered gaps occur.
  initial begin : idle_pattern
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
    end
  end

  // The slowest legal run stays well under a tenth of this.
  initial begin : watchdog
    #10ms;
    $display("Verification failed");
    $finish;
  end

  initial begin : run_tests
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_PIXEL;
    in_red          = '0;
    in_green        = '0;
    in_blue         = '0;
    in_row_end      = 1'b0;
    in_matrix_slot  = '0;
    in_matrix_value = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_MODE;
    cfg_data        = '0;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_load_matrix();
    test_color_codes();
    test_ignored_and_load();
    test_start_of_frame();
    test_plane_count_limits();
    test_palette_base();
    test_mode_switch_in_group();
    test_random_traffic();
    settle();

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
